>>> sv/tte_pkg.sv
package tte_pkg;

    localparam int TIME_W       = 32;
    localparam int GAP_W        = 24;
    localparam int TEMPO_W      = 24;
    localparam int NUM_TAPS_DEF = 4;

    localparam logic [GAP_W-1:0] GAP_RESET = 24'd2000000;

    // 60e6 us per minute times 100 for hundredths of BPM
    localparam int                CENTI_W      = 33;
    localparam logic [CENTI_W-1:0] CENTI_BPM_US = 33'd6000000000;

    localparam logic [TEMPO_W-1:0] TEMPO_MAX = '1;

    typedef struct packed {
        logic done;
        logic has_interval;
    } hist_stat_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

    function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> sv/tte_history.sv
module tte_history import tte_pkg::*; #(
    parameter int NUM_TAPS = NUM_TAPS_DEF,
    parameter int SUM_W    = TIME_W + $clog2(NUM_TAPS_DEF),
    parameter int NUM_W    = CENTI_W + $clog2(NUM_TAPS_DEF)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] now,
    input  logic [GAP_W-1:0]  gap,
    output hist_stat_t        stat,
    output logic [SUM_W-1:0]  sum,
    output logic [NUM_W-1:0]  num
);

    localparam int              IDX_W    = $clog2(NUM_TAPS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TAPS - 1);

    typedef enum logic [1:0] {H_IDLE, H_CHECK, H_UPDATE, H_SUM} hstate_t;

    hstate_t           state_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] now_reg;
    logic              restart_reg;
    logic [TIME_W-1:0] hist_reg [NUM_TAPS];
    logic [SUM_W-1:0]  sum_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              any_reg;
    logic              done_reg;

    logic [TIME_W-1:0] gap_ext;
    logic              chk_bad;
    logic [TIME_W-1:0] pair_d;

    // history is rotated one place per cycle so only the front two taps are compared
    assign gap_ext = {{(TIME_W - GAP_W){1'b0}}, gap};
    assign chk_bad = (hist_reg[0] == '0) || (abs_diff(hist_reg[0], now_reg) > gap_ext);
    assign pair_d  = abs_diff(hist_reg[0], hist_reg[1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
            any_reg   <= 1'b0;
            for (int i = 0; i < NUM_TAPS; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                H_IDLE: begin
                    if (start) begin
                        now_reg     <= now;
                        restart_reg <= 1'b0;
                        idx_reg     <= '0;
                        state_reg   <= H_CHECK;
                    end
                end
                H_CHECK: begin
                    if (chk_bad) begin
                        restart_reg <= 1'b1;
                    end
                    for (int i = 0; i < NUM_TAPS - 1; i++) begin
                        hist_reg[i] <= hist_reg[i+1];
                    end
                    hist_reg[NUM_TAPS-1] <= hist_reg[0];
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST) begin
                        state_reg <= H_UPDATE;
                    end
                end
                H_UPDATE: begin
                    hist_reg[0] <= now_reg;
                    for (int i = 1; i < NUM_TAPS; i++) begin
                        hist_reg[i] <= restart_reg ? now_reg : hist_reg[i-1];
                    end
                    sum_reg   <= '0;
                    num_reg   <= '0;
                    any_reg   <= 1'b0;
                    idx_reg   <= '0;
                    state_reg <= H_SUM;
                end
                H_SUM: begin
                    // the wrap pair (oldest, newest) on the last step is not an interval
                    if (idx_reg != IDX_LAST && pair_d != '0) begin
                        sum_reg <= sum_reg + SUM_W'(pair_d);
                        num_reg <= num_reg + NUM_W'(CENTI_BPM_US);
                        any_reg <= 1'b1;
                    end
                    for (int i = 0; i < NUM_TAPS - 1; i++) begin
                        hist_reg[i] <= hist_reg[i+1];
                    end
                    hist_reg[NUM_TAPS-1] <= hist_reg[0];
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST) begin
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    assign stat = '{done: done_reg, has_interval: any_reg};
    assign sum  = sum_reg;
    assign num  = num_reg;

endmodule

>>> sv/tte_divider.sv
module tte_divider import tte_pkg::*; #(
    parameter int NUM_W = CENTI_W + $clog2(NUM_TAPS_DEF),
    parameter int DEN_W = TIME_W + $clog2(NUM_TAPS_DEF)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [NUM_W-1:0]   dividend,
    input  logic [DEN_W-1:0]   divisor,
    output div_stat_t          stat,
    output logic [TEMPO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   dvd_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [TEMPO_W-1:0] q_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DEN_W:0] rem_shift;
    logic [DEN_W:0] den_ext;
    logic [DEN_W:0] rem_sub;
    logic           ge;

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, dvd_reg[NUM_W-1]};
    assign den_ext   = {1'b0, divisor};
    assign rem_sub   = rem_shift - den_ext;
    assign ge        = rem_shift >= den_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg  <= dividend;
                rem_reg  <= '0;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                dvd_reg <= {dvd_reg[NUM_W-2:0], 1'b0};
                q_reg   <= {q_reg[TEMPO_W-2:0], ge};
                // a one leaving the top of the quotient means out of range
                ovf_reg <= ovf_reg | q_reg[TEMPO_W-1];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat     = '{done: done_reg, sat: ovf_reg};
    assign quotient = ovf_reg ? TEMPO_MAX : q_reg;

endmodule

>>> sv/tap_tempo_estimator.sv
// Tap tempo estimator.
// s_ channel: one tap timestamp per transaction, s_tdata = tap_time_us (32 bits, us).
// m_ channel: one result per tap, m_tdata = tempo_centi_bpm (hundredths of BPM),
//   m_tuser = saturated (tempo clipped to the 24-bit maximum).
// cfg_wr_en / cfg_wr_data write max_gap_us; write it only while no tap is in flight.
// The block keeps the last NUM_TAPS taps and averages the nonzero intervals between them;
// a tap too far from the stored ones (or an empty slot) restarts the history.
// An accepted tap passes through the history check scan, the history update, the
//   interval sum scan and the serial divider, which takes one bit step per bit of
//   its NUM_W = 33 + clog2(NUM_TAPS) bit dividend. Taps with no interval skip the divider.
// A new tap is taken only after the history scan and the divider are through with the
// previous tap and its result has been loaded into the output register.
// s_tready is high whenever no tap is being worked on, even while a result waits
// on a stalled m_ side; a finished result is held in its state until the output
// register is free, then the next tap is taken.
// Reset empties the history, sets max_gap_us to 2000000 and drops m_tvalid.
module tap_tempo_estimator import tte_pkg::*; #(
    parameter int NUM_TAPS = NUM_TAPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [GAP_W-1:0]   cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TIME_W-1:0]  s_tdata,   // [31:0] tap_time_us
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TEMPO_W-1:0] m_tdata,   // [23:0] tempo_centi_bpm
    output logic [0:0]         m_tuser    // [0] saturated
);

    localparam int CNT_W = $clog2(NUM_TAPS);
    localparam int SUM_W = TIME_W + CNT_W;
    localparam int NUM_W = CENTI_W + CNT_W;

    typedef enum logic [1:0] {S_IDLE, S_HIST, S_DIV, S_OUT} state_t;

    state_t             state_reg;
    logic [GAP_W-1:0]   gap_reg;
    logic [TEMPO_W-1:0] res_tempo_reg;
    logic               res_sat_reg;
    logic               div_start_reg;
    logic               m_tvalid_reg;
    logic [TEMPO_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    hist_stat_t         hist_stat;
    div_stat_t          div_stat;
    logic [SUM_W-1:0]   sum;
    logic [NUM_W-1:0]   num;
    logic [TEMPO_W-1:0] quotient;
    logic               s_accept;
    logic               out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    tte_history #(
        .NUM_TAPS (NUM_TAPS),
        .SUM_W    (SUM_W),
        .NUM_W    (NUM_W)
    ) u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .now     (s_tdata),
        .gap     (gap_reg),
        .stat    (hist_stat),
        .sum     (sum),
        .num     (num)
    );

    tte_divider #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (num),
        .divisor  (sum),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            gap_reg       <= GAP_RESET;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (cfg_wr_en) begin
                gap_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= res_tempo_reg;
                m_tuser_reg  <= res_sat_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        state_reg <= S_HIST;
                    end
                end
                S_HIST: begin
                    if (hist_stat.done) begin
                        if (hist_stat.has_interval) begin
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end else begin
                            res_tempo_reg <= '0;
                            res_sat_reg   <= 1'b0;
                            state_reg     <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        res_tempo_reg <= quotient;
                        res_sat_reg   <= div_stat.sat;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

>>> tb/sv/tap_tempo_checker.sv
module tap_tempo_checker import tte_pkg::*; #(
    parameter int NUM_TAPS = NUM_TAPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [GAP_W-1:0]   cfg_wr_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TIME_W-1:0]  s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TEMPO_W-1:0] m_tdata,
    input  logic [0:0]         m_tuser,
    output int                 mismatches,
    output int                 pending
);

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo;
        logic               saturated;
    } tempo_result_t;

    logic [TIME_W-1:0] tap_log [NUM_TAPS];
    logic [GAP_W-1:0]  gap_us;
    tempo_result_t     tempo_q [$];

    function automatic logic [TIME_W-1:0] tap_distance(input logic [TIME_W-1:0] x,
                                                       input logic [TIME_W-1:0] y);
        return (x > y) ? x - y : y - x;
    endfunction

    // Updates the tap log with one tap and returns the tempo it implies.
    function automatic tempo_result_t log_tap(input logic [TIME_W-1:0] now);
        logic          restart;
        logic [63:0]   span_sum;
        logic [63:0]   n_intervals;
        logic [63:0]   quot;
        tempo_result_t res;
        restart = 1'b0;
        for (int i = 0; i < NUM_TAPS; i++) begin
            if (tap_log[i] == '0)
                restart = 1'b1;
            else if (tap_distance(tap_log[i], now) > TIME_W'(gap_us))
                restart = 1'b1;
        end
        if (restart) begin
            for (int i = 0; i < NUM_TAPS; i++)
                tap_log[i] = now;
        end else begin
            for (int i = NUM_TAPS - 1; i > 0; i--)
                tap_log[i] = tap_log[i-1];
            tap_log[0] = now;
        end
        span_sum    = '0;
        n_intervals = '0;
        for (int i = 1; i < NUM_TAPS; i++) begin
            if (tap_distance(tap_log[i], tap_log[i-1]) != '0) begin
                span_sum    = span_sum + 64'(tap_distance(tap_log[i], tap_log[i-1]));
                n_intervals = n_intervals + 64'd1;
            end
        end
        res = '0;
        if (n_intervals != '0) begin
            quot = (64'(CENTI_BPM_US) * n_intervals) / span_sum;
            if (quot > 64'(TEMPO_MAX)) begin
                res.tempo     = TEMPO_MAX;
                res.saturated = 1'b1;
            end else begin
                res.tempo = quot[TEMPO_W-1:0];
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        tempo_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_TAPS; i++)
                tap_log[i] = '0;
            gap_us = GAP_RESET;
            tempo_q.delete();
        end else begin
            if (cfg_wr_en)
                gap_us = cfg_wr_data;
            if (s_tvalid && s_tready)
                tempo_q.push_back(log_tap(s_tdata));
            if (m_tvalid && m_tready) begin
                if (tempo_q.size() == 0) begin
                    $error("result transaction with no tap outstanding: tempo_centi_bpm %0d",
                           m_tdata);
                    mismatches++;
                end else begin
                    want = tempo_q.pop_front();
                    if (m_tdata !== want.tempo) begin
                        $error("tempo_centi_bpm: expected %0d, actual %0d", want.tempo, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.saturated) begin
                        $error("saturated: expected %0d, actual %0d", want.saturated,
                               m_tuser[0]);
                        mismatches++;
                    end
                end
            end
        end
        pending = tempo_q.size();
    end

endmodule

>>> tb/sv/tap_tempo_estimator_tb.sv
module tap_tempo_estimator_tb;
    import tte_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int RUN_LEN     = 67;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [GAP_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TIME_W-1:0]  s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TEMPO_W-1:0] m_tdata;
    logic [0:0]         m_tuser;

    int mismatches;
    int pending;
    int send_idle_pct  = 16;
    int recv_stall_pct = 59;
    int quiet_cycles   = 0;

    logic [TIME_W-1:0] tap_clock;
    logic [GAP_W-1:0]  cur_gap;

    always #6 aclk = ~aclk;

    tap_tempo_estimator DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    tap_tempo_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // no transaction on either side for too long means a hang
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tap_tempo_estimator test failed");
            $finish;
        end
    end

    task automatic send_tap(input logic [TIME_W-1:0] t);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = t;
        taken    = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_tready;
        end
        @(negedge aclk);
        tap_clock = t;
    endtask

    task automatic write_gap(input logic [GAP_W-1:0] g);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = g;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cur_gap   = g;
    endtask

    // Mostly tap sequences that stay inside the gap, with restarts, zero taps,
    // repeats, reversals and fresh random timestamps mixed in.
    task automatic tap_run(input int n);
        int unsigned       pick;
        logic [TIME_W-1:0] step;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                step = $urandom_range(0, 400);
                send_tap(tap_clock + step);
            end else if (pick < 70) begin
                step = $urandom_range(0, cur_gap);
                send_tap(tap_clock + step);
            end else if (pick < 80) begin
                send_tap($urandom());
            end else if (pick < 85) begin
                send_tap('0);
            end else if (pick < 90) begin
                send_tap(tap_clock);
            end else if (pick < 95) begin
                step = $urandom_range(0, cur_gap);
                send_tap(tap_clock - step);
            end else begin
                step = TIME_W'(cur_gap) + 1 + $urandom_range(0, 1000);
                send_tap(tap_clock + step);
            end
        end
    endtask

    initial begin
        tap_clock = '0;
        cur_gap   = GAP_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // regular beat at 120 BPM, then a repeat and very short intervals
        send_tap(32'd1000000);
        send_tap(32'd1500000);
        send_tap(32'd2000000);
        send_tap(32'd2500000);
        send_tap(32'd2500000);
        send_tap(32'd2500100);
        send_tap(32'd2500150);
        send_tap(32'd2500200);
        send_tap(32'd2500250);
        // zero timestamp reads as empty on the next tap
        send_tap(32'd0);
        send_tap(32'd5);
        send_tap(32'hFFFF_FFFF);
        send_tap(32'hFFFF_FFFF - 32'd600000);
        send_tap(32'hFFFF_FFFF - 32'd1200000);
        send_tap(32'hFFFF_FFFF - 32'd3300000);

        write_gap('0);
        send_tap(32'd7000000);
        send_tap(32'd7000000);
        send_tap(32'd7000001);

        write_gap('1);
        send_tap(32'd100);
        send_tap(32'd16777315);
        send_tap(32'd33554431);

        write_gap(24'd1);
        send_tap(32'd40);
        send_tap(32'd41);
        send_tap(32'd42);
        send_tap(32'd43);
        send_tap(32'd45);

        for (int p = 0; p < 3; p++) begin
            if (p == 0) begin
                send_idle_pct  = 16;
                recv_stall_pct = 59;
            end else if (p == 1) begin
                send_idle_pct  = 59;
                recv_stall_pct = 16;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_gap(p == 0 ? GAP_W'($urandom()) : (p == 1 ? 24'd16000000 : GAP_RESET));
            tap_clock = $urandom();
            tap_run(RUN_LEN);
            write_gap(GAP_W'($urandom_range(1, 16000000)));
            tap_run(RUN_LEN);
        end

        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (64) @(posedge aclk);
        if (mismatches == 0)
            $display("tap_tempo_estimator test passed");
        else
            $display("tap_tempo_estimator test failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/tte_pkg.sv
sv/tte_history.sv
sv/tte_divider.sv
sv/tap_tempo_estimator.sv
tb/sv/tap_tempo_checker.sv
tb/sv/tap_tempo_estimator_tb.sv
